@@ rtl/core/bssr_pkg.sv @@
// Shared types, constants and register indexes for the belt ramp unit.
`timescale 1ns / 1ps

package bssr_pkg;

   localparam int CfgWidth   = 16;
   localparam int StepWidth  = 4;
   localparam int SpeedWidth = 3;
   localparam int CsrIdxWidth = 2;

   localparam logic [StepWidth-1:0]  StepIdle    = 4'd0;
   localparam logic [StepWidth-1:0]  StepOne     = 4'd1;
   localparam logic [StepWidth-1:0]  StepThree   = 4'd3;
   localparam logic [StepWidth-1:0]  StepLong    = 4'd5;
   localparam logic [StepWidth-1:0]  StepLast    = 4'd7;
   localparam logic [StepWidth-1:0]  StepFull    = 4'd8;
   localparam logic [SpeedWidth-1:0] SpeedStop   = 3'd0;
   localparam logic [SpeedWidth-1:0] SpeedTop    = 3'd6;

   localparam logic [CfgWidth-1:0] UpDwellBaseReset   = 16'd400;
   localparam logic [CfgWidth-1:0] DownDwellBaseReset = 16'd400;
   localparam logic [CfgWidth-1:0] StopDelayReset     = 16'd200;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_UP_DWELL_BASE   = 2'd0,
      CSR_DOWN_DWELL_BASE = 2'd1,
      CSR_STOP_DELAY      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CfgWidth-1:0] up_dwell_base;
      logic [CfgWidth-1:0] down_dwell_base;
      logic [CfgWidth-1:0] stop_delay_ticks;
   } cfg_type;

   typedef struct packed {
      logic [StepWidth-1:0]  step_index;
      logic [SpeedWidth-1:0] speed_out;
      logic                  start_request;
      logic                  stop_request;
      logic                  running_flag;
      logic                  stop_done;
      logic                  delay_active;
      logic [CfgWidth-1:0]   up_dwell_count;
      logic [CfgWidth-1:0]   down_dwell_count;
      logic [CfgWidth-1:0]   delay_count;
   } ramp_state_type;

endpackage

@@ rtl/core/belt_soft_start_stop_ramp_unit.sv @@
// Top level of the belt soft start / soft stop ramp unit.
`timescale 1ns / 1ps
//
// One req transaction is one timer tick carrying the qualified presence bit
// (req_sensor_present). Each tick yields exactly one rsp transaction with the
// speed code, running flag, ramp step and stop-pending flag after that tick.
// Configuration (up dwell base, down dwell base, stop delay ticks) is written
// through the csr port, index 0..2, by the user only while no tick is in flight
// (the block does not enforce this); other indexes are ignored.
// A tick accepted on req is held in the input register, then evaluated into the
// ramp state and result register, raising rsp_valid, once the result slot is free.
// Throughput: one tick per cycle while rsp_ready holds; the ramp state register
// closes the only loop, so each tick sees the state left by the previous one.
// Stalls: the input register accepts a new tick while a result waits; when
// rsp_ready is low with both registers full, req_ready drops and the result
// and ramp state hold.
// Reset: synchronous; the ramp state clears to step 0, speed 0 and the
// timing registers return to 400, 400 and 200 ticks.

module belt_soft_start_stop_ramp_unit
   import bssr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_sensor_present,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SpeedWidth-1:0]  rsp_speed_code,
   output logic                   rsp_running,
   output logic [StepWidth-1:0]   rsp_ramp_step,
   output logic                   rsp_stop_pending,
   input  logic                   csr_write_enable,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_write_data
);

   cfg_type        cfg;
   ramp_state_type state_ff;
   ramp_state_type state_in;
   ramp_state_type tick_next;
   logic           in_valid_ff;
   logic           in_valid_in;
   logic           in_present_ff;
   logic           in_present_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic           advance;

   bssr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bssr_tick u_tick (
      .cur     (state_ff),
      .cfg     (cfg),
      .present (in_present_ff),
      .nxt     (tick_next)
   );

   // evaluate the held tick once the result slot is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_present_in = in_present_ff;
      out_valid_in  = out_valid_ff;
      state_in      = state_ff;
      if (rsp_valid && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         state_in     = tick_next;
      end
      if (req_valid && req_ready) begin
         in_valid_in   = 1'b1;
         in_present_in = req_sensor_present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_present_ff <= in_present_in;
   end

   // the ramp state only changes together with a new result
   assign rsp_valid        = out_valid_ff;
   assign rsp_speed_code   = state_ff.speed_out;
   assign rsp_running      = state_ff.running_flag;
   assign rsp_ramp_step    = state_ff.step_index;
   assign rsp_stop_pending = state_ff.delay_active;

   a_running_at_full: assert property (@(posedge clock) disable iff (reset)
      state_ff.running_flag |-> (state_ff.step_index == StepFull))
      else $error("running set below full step");

   a_delay_not_running: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.delay_active && state_ff.running_flag))
      else $error("stop delay counting while running");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.step_index <= StepFull)
      else $error("ramp step beyond full");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> $stable(state_ff))
      else $error("ramp state moved while result stalled");

endmodule

@@ rtl/core/bssr_csr.sv @@
// Configuration registers for dwell and stop-delay timing.
`timescale 1ns / 1ps

module bssr_csr
   import bssr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_write_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_UP_DWELL_BASE:   cfg_in.up_dwell_base    = csr_write_data;
            CSR_DOWN_DWELL_BASE: cfg_in.down_dwell_base  = csr_write_data;
            CSR_STOP_DELAY:      cfg_in.stop_delay_ticks = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_dwell_base    <= UpDwellBaseReset;
         cfg_ff.down_dwell_base  <= DownDwellBaseReset;
         cfg_ff.stop_delay_ticks <= StopDelayReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/bssr_tick.sv @@
// Next-state logic for one timer tick: presence handling, ramps and stop delay.
`timescale 1ns / 1ps

module bssr_tick
   import bssr_pkg::*;
(
   input  ramp_state_type cur,
   input  cfg_type        cfg,
   input  logic           present,
   output ramp_state_type nxt
);

   logic [CfgWidth-1:0] up_limit;
   logic [CfgWidth-1:0] down_limit;

   always_comb begin
      nxt = cur;

      if (present) begin
         if (!cur.start_request) begin
            nxt.start_request = 1'b1;
            nxt.stop_request  = 1'b0;
            nxt.running_flag  = 1'b0;
            nxt.stop_done     = 1'b0;
            nxt.delay_active  = 1'b0;
            if (cur.step_index != StepIdle) begin
               nxt.step_index = cur.step_index - 4'd1;
            end
         end
      end else begin
         if (cur.running_flag) begin
            nxt.delay_active  = 1'b1;
            nxt.running_flag  = 1'b0;
            nxt.start_request = 1'b0;
         end
         if (cur.stop_done) begin
            nxt.stop_request  = 1'b1;
            nxt.start_request = 1'b0;
            nxt.stop_done     = 1'b0;
         end
      end

      // ramp-up: step 5 dwells the full base, others a quarter
      up_limit = (nxt.step_index == StepLong) ? cfg.up_dwell_base
                                              : (cfg.up_dwell_base >> 2);
      if (nxt.start_request) begin
         if (nxt.step_index == StepIdle) begin
            nxt.speed_out  = SpeedStop;
            nxt.step_index = StepOne;
         end else if (nxt.step_index > StepLast) begin
            nxt.up_dwell_count = '0;
         end else begin
            nxt.speed_out = (nxt.step_index == StepLast) ? SpeedTop
                                                         : nxt.step_index[SpeedWidth-1:0];
            nxt.up_dwell_count = nxt.up_dwell_count + 16'd1;
            if (nxt.up_dwell_count >= up_limit) begin
               if (nxt.step_index == StepLast) begin
                  nxt.running_flag = 1'b1;
               end
               nxt.step_index     = nxt.step_index + 4'd1;
               nxt.up_dwell_count = '0;
            end
         end
      end

      // ramp-down: low steps dwell a quarter, upper steps half the base
      down_limit = (nxt.step_index <= StepThree) ? (cfg.down_dwell_base >> 2)
                                                 : (cfg.down_dwell_base >> 1);
      if (nxt.stop_request) begin
         if (nxt.step_index == StepIdle || nxt.step_index > StepFull) begin
            nxt.speed_out        = SpeedStop;
            nxt.down_dwell_count = '0;
         end else if (nxt.step_index == StepOne) begin
            nxt.speed_out        = SpeedStop;
            nxt.step_index       = StepIdle;
            nxt.down_dwell_count = '0;
            nxt.running_flag     = 1'b0;
         end else begin
            nxt.speed_out = (nxt.step_index == StepFull) ? SpeedTop
                                                         : nxt.step_index[SpeedWidth-1:0] - 3'd1;
            nxt.down_dwell_count = nxt.down_dwell_count + 16'd1;
            if (nxt.down_dwell_count >= down_limit) begin
               nxt.step_index       = nxt.step_index - 4'd1;
               nxt.down_dwell_count = '0;
            end
         end
      end

      if (nxt.delay_active) begin
         nxt.delay_count = nxt.delay_count + 16'd1;
         if (nxt.delay_count >= cfg.stop_delay_ticks) begin
            nxt.stop_done    = 1'b1;
            nxt.delay_active = 1'b0;
            nxt.delay_count  = '0;
         end
      end
   end

endmodule

@@ tb/belt_ramp_checker.sv @@
// Checker for the belt ramp unit: predicts each tick's result and compares it.
`timescale 1ns / 1ps

module belt_ramp_checker
   import bssr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_sensor_present,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [SpeedWidth-1:0]  rsp_speed_code,
   input  logic                   rsp_running,
   input  logic [StepWidth-1:0]   rsp_ramp_step,
   input  logic                   rsp_stop_pending,
   input  logic                   csr_write_enable,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_write_data,
   output int                     error_count,
   output int                     pending_count
);

   typedef struct packed {
      logic [SpeedWidth-1:0] speed_code;
      logic                  running;
      logic [StepWidth-1:0]  ramp_step;
      logic                  stop_pending;
   } belt_status_type;

   ramp_state_type  motor_state;
   cfg_type         timing;
   belt_status_type expected_status[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // One timer tick of the soft start / soft stop ramp.
   function automatic ramp_state_type advance_ramp(input ramp_state_type s,
                                                   input cfg_type c,
                                                   input logic present);
      logic [CfgWidth-1:0]  limit;
      logic [StepWidth-1:0] step_less;
      if (present) begin
         if (!s.start_request) begin
            s.start_request = 1'b1;
            s.stop_request  = 1'b0;
            s.running_flag  = 1'b0;
            s.stop_done     = 1'b0;
            s.delay_active  = 1'b0;
            // restart one step below; dwell count is kept on purpose
            if (s.step_index != StepIdle) s.step_index = s.step_index - 1'b1;
         end
      end else begin
         if (s.running_flag) begin
            s.delay_active  = 1'b1;
            s.running_flag  = 1'b0;
            s.start_request = 1'b0;
         end
         if (s.stop_done) begin
            s.stop_request  = 1'b1;
            s.start_request = 1'b0;
            s.stop_done     = 1'b0;
         end
      end

      if (s.start_request) begin
         if (s.step_index == StepIdle) begin
            s.speed_out  = SpeedStop;
            s.step_index = StepOne;
         end else if (s.step_index > StepLast) begin
            s.up_dwell_count = '0;
         end else begin
            s.speed_out = (s.step_index == StepLast) ? SpeedTop :
                          s.step_index[SpeedWidth-1:0];
            limit = (s.step_index == StepLong) ? c.up_dwell_base : (c.up_dwell_base >> 2);
            s.up_dwell_count = s.up_dwell_count + 1'b1;
            if (s.up_dwell_count >= limit) begin
               if (s.step_index == StepLast) s.running_flag = 1'b1;
               s.step_index     = s.step_index + 1'b1;
               s.up_dwell_count = '0;
            end
         end
      end

      if (s.stop_request) begin
         if (s.step_index == StepIdle || s.step_index > StepFull) begin
            s.speed_out        = SpeedStop;
            s.down_dwell_count = '0;
         end else if (s.step_index == StepOne) begin
            s.speed_out        = SpeedStop;
            s.step_index       = StepIdle;
            s.down_dwell_count = '0;
            s.running_flag     = 1'b0;
         end else begin
            step_less   = s.step_index - 1'b1;
            s.speed_out = (s.step_index == StepFull) ? SpeedTop : step_less[SpeedWidth-1:0];
            limit = (s.step_index <= StepThree) ? (c.down_dwell_base >> 2) :
                    (c.down_dwell_base >> 1);
            s.down_dwell_count = s.down_dwell_count + 1'b1;
            if (s.down_dwell_count >= limit) begin
               s.step_index       = s.step_index - 1'b1;
               s.down_dwell_count = '0;
            end
         end
      end

      if (s.delay_active) begin
         s.delay_count = s.delay_count + 1'b1;
         if (s.delay_count >= c.stop_delay_ticks) begin
            s.stop_done    = 1'b1;
            s.delay_active = 1'b0;
            s.delay_count  = '0;
         end
      end
      return s;
   endfunction

   always @(posedge clock) begin
      belt_status_type want;
      if (reset) begin
         motor_state            = '0;
         timing.up_dwell_base    = UpDwellBaseReset;
         timing.down_dwell_base  = DownDwellBaseReset;
         timing.stop_delay_ticks = StopDelayReset;
         expected_status.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_UP_DWELL_BASE:   timing.up_dwell_base    = csr_write_data;
               CSR_DOWN_DWELL_BASE: timing.down_dwell_base  = csr_write_data;
               CSR_STOP_DELAY:      timing.stop_delay_ticks = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            motor_state       = advance_ramp(motor_state, timing, req_sensor_present);
            want.speed_code   = motor_state.speed_out;
            want.running      = motor_state.running_flag;
            want.ramp_step    = motor_state.step_index;
            want.stop_pending = motor_state.delay_active;
            expected_status.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               $error("unexpected rsp transaction: speed_code %0d ramp_step %0d",
                      rsp_speed_code, rsp_ramp_step);
               error_count++;
            end else begin
               want = expected_status.pop_front();
               if (rsp_speed_code !== want.speed_code) begin
                  $error("speed_code: expected %0d, actual %0d", want.speed_code,
                         rsp_speed_code);
                  error_count++;
               end
               if (rsp_running !== want.running) begin
                  $error("running: expected %0d, actual %0d", want.running, rsp_running);
                  error_count++;
               end
               if (rsp_ramp_step !== want.ramp_step) begin
                  $error("ramp_step: expected %0d, actual %0d", want.ramp_step,
                         rsp_ramp_step);
                  error_count++;
               end
               if (rsp_stop_pending !== want.stop_pending) begin
                  $error("stop_pending: expected %0d, actual %0d", want.stop_pending,
                         rsp_stop_pending);
                  error_count++;
               end
            end
         end
      end
      pending_count = expected_status.size();
   end

endmodule

@@ tb/belt_soft_start_stop_ramp_unit_tb.sv @@
// Testbench top for the belt ramp unit: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps

module belt_soft_start_stop_ramp_unit_tb;
   import bssr_pkg::*;

   localparam int                     WatchdogLimit  = 4000;
   localparam int                     RandomTicks    = 1700;
   localparam int                     LongHoldCycles = 250;
   localparam logic [CsrIdxWidth-1:0] CsrUnusedIndex = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_sensor_present;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [SpeedWidth-1:0]  rsp_speed_code;
   logic                   rsp_running;
   logic [StepWidth-1:0]   rsp_ramp_step;
   logic                   rsp_stop_pending;
   logic                   csr_write_enable;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CfgWidth-1:0]    csr_write_data;

   int          error_count;
   int          pending_count;
   int          idle_cycles;
   bit          send_busy = 1'b0;
   bit          long_hold = 1'b0;
   int unsigned cfg_start;
   int unsigned cfg_stop;
   int unsigned cfg_delay;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   belt_soft_start_stop_ramp_unit DUT (.*);

   belt_ramp_checker ramp_checker (.*);

   // Abort when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random back-pressure, with a long hold-off on request.
   initial begin
      int unsigned stall;
      int unsigned taken;
      bit          recv_busy;
      rsp_ready = 1'b0;
      taken     = 0;
      recv_busy = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready = 1'b0;
            repeat (LongHoldCycles) @(negedge clock);
            long_hold = 1'b0;
         end
         if (taken % 64 == 0) recv_busy = ($urandom_range(0, 2) == 0);
         stall = recv_busy ? 0 : $urandom_range(0, 17);
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   task automatic send_tick(input logic present);
      int unsigned gap;
      gap = send_busy ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          = 1'b1;
      req_sensor_present = present;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering ticks and let every outstanding result come back.
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CfgWidth-1:0] value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic program_timing(input int unsigned start_t, input int unsigned stop_t,
                                 input int unsigned delay_t);
      cfg_start = start_t;
      cfg_stop  = stop_t;
      cfg_delay = delay_t;
      write_csr(CSR_UP_DWELL_BASE, start_t[CfgWidth-1:0]);
      write_csr(CSR_DOWN_DWELL_BASE, stop_t[CfgWidth-1:0]);
      write_csr(CSR_STOP_DELAY, delay_t[CfgWidth-1:0]);
      // writes to the spare index must be dropped
      if ($urandom_range(0, 3) == 0)
         write_csr(CsrUnusedIndex, CfgWidth'($urandom_range(0, 65535)));
   endtask

   function automatic int unsigned pick_timing();
      int unsigned roll;
      roll = $urandom_range(0, 11);
      if (roll == 0) return 65535;
      if (roll <= 3) return $urandom_range(0, 3);
      return $urandom_range(4, 40);
   endfunction

   // Ticks spent in one dwell, clamped so that huge limits stay bounded.
   function automatic int unsigned dwell_ticks(input int unsigned limit);
      if (limit == 0) return 1;
      return (limit > 40) ? 40 : limit;
   endfunction

   // Presence burst followed by absence, sized to the current dwells; some noise.
   task automatic send_burst(output int unsigned sent);
      int unsigned up_len;
      int unsigned down_len;
      int unsigned on_ticks;
      int unsigned off_ticks;
      up_len   = 2 + 6 * dwell_ticks(cfg_start >> 2) + dwell_ticks(cfg_start);
      down_len = 2 + dwell_ticks(cfg_delay) + 2 * dwell_ticks(cfg_stop >> 2) +
                 5 * dwell_ticks(cfg_stop >> 1);
      if ($urandom_range(0, 9) < 7) begin
         on_ticks  = $urandom_range(1, up_len + 4);
         off_ticks = $urandom_range(1, down_len + 4);
         repeat (on_ticks) send_tick(1'b1);
         repeat (off_ticks) send_tick(1'b0);
         sent = on_ticks + off_ticks;
      end else begin
         on_ticks = $urandom_range(1, 20);
         repeat (on_ticks) send_tick($urandom_range(0, 1));
         sent = on_ticks;
      end
   endtask

   initial begin
      logic [23:0] directed_ticks;
      int unsigned total;
      int unsigned phase;
      int unsigned phase_len;
      int unsigned phase_ticks;
      int unsigned burst;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_sensor_present = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_UP_DWELL_BASE;
      csr_write_data     = '0;
      cfg_start          = UpDwellBaseReset;
      cfg_stop           = DownDwellBaseReset;
      cfg_delay          = StopDelayReset;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero dwell bases and a stop delay of 2 ticks: full ramp-up, stop delay cut short
      // by presence, resumed delay, then full ramp-down.
      program_timing(0, 0, 2);
      directed_ticks = {9'h1FF, 1'b0, 3'b111, 11'd0};
      for (int i = 23; i >= 0; i--) send_tick(directed_ticks[i]);

      total = 0;
      phase = 0;
      while (total < RandomTicks) begin
         drain_results();
         case (phase)
            0:       program_timing(65535, 65535, 65535);
            1:       program_timing(0, 0, 0);
            default: program_timing(pick_timing(), pick_timing(), pick_timing());
         endcase
         send_busy = ($urandom_range(0, 2) == 0);
         if (phase == 2 || phase == 7) begin
            // stall the result side while ticks keep coming
            long_hold = 1'b1;
            send_busy = 1'b1;
         end
         phase_len   = (phase < 2) ? 40 : $urandom_range(60, 200);
         phase_ticks = 0;
         while (phase_ticks < phase_len) begin
            send_burst(burst);
            phase_ticks += burst;
         end
         total += phase_ticks;
         phase++;
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
